// ===== rtl/core/imu_tcf_pkg.sv =====
// Package for the IMU tilt complementary filter: constants, types and the
// CORDIC arctangent table. No dependencies.
`default_nettype none
package imu_tcf_pkg;

    localparam int CordicSteps = 16;
    localparam int StepW       = $clog2(CordicSteps + 1);
    localparam int SqrtSteps   = 31;
    localparam int SqrtCntW    = $clog2(SqrtSteps + 1);

    localparam logic [15:0] AlphaReset = 16'd49874;
    localparam logic [16:0] OneQ16     = 17'd65536;
    localparam logic [16:0] WAcc       = 17'd1966;
    localparam logic [16:0] WEst       = 17'd63570;
    localparam logic [17:0] GyroDt     = 18'd167772;
    localparam logic signed [31:0] AccLim = 32'sd1073741824;

    // Datapath commands issued by the controller
    typedef enum logic [3:0] {
        CMD_NONE    = 4'd0,
        CMD_LOAD    = 4'd1,
        CMD_FILT    = 4'd2,
        CMD_SQ      = 4'd3,
        CMD_SQRT_I  = 4'd4,
        CMD_SQRT    = 4'd5,
        CMD_CORD_I  = 4'd6,
        CMD_CORD    = 4'd7,
        CMD_FUSE_A  = 4'd8,
        CMD_FUSE_B  = 4'd9,
        CMD_FUSE_C  = 4'd10,
        CMD_OUT     = 4'd11
    } cmd_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [1:0]  axis;   // filter axis, or 0 = pitch / 1 = roll
    } ctrl_t;

    typedef struct packed {
        logic sqrt_done;
        logic cord_done;
    } stat_t;

    function automatic logic signed [31:0] atan_lut(input logic [4:0] i);
        logic signed [31:0] r;
        case (i)
            5'd0:  r = 32'sd2949120;  5'd1:  r = 32'sd1740967;
            5'd2:  r = 32'sd919879;   5'd3:  r = 32'sd466945;
            5'd4:  r = 32'sd234379;   5'd5:  r = 32'sd117304;
            5'd6:  r = 32'sd58666;    5'd7:  r = 32'sd29335;
            5'd8:  r = 32'sd14668;    5'd9:  r = 32'sd7334;
            5'd10: r = 32'sd3667;     5'd11: r = 32'sd1833;
            5'd12: r = 32'sd917;      5'd13: r = 32'sd458;
            5'd14: r = 32'sd229;      5'd15: r = 32'sd115;
            5'd16: r = 32'sd57;       5'd17: r = 32'sd29;
            5'd18: r = 32'sd14;       5'd19: r = 32'sd7;
            5'd20: r = 32'sd4;        5'd21: r = 32'sd2;
            5'd22: r = 32'sd1;        default: r = 32'sd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/imu_tcf_ctrl.sv =====
// Controller for the IMU tilt filter: sequences filter, square root,
// CORDIC and fuse steps. Depends on imu_tcf_pkg.
`default_nettype none
module imu_tcf_ctrl
    import imu_tcf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_go,
    input  wire logic  out_free,
    input  wire stat_t stat,
    output ctrl_t      ctrl,
    output logic       busy,
    output logic       out_load
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_FILT   = 11'b00000000010,
        S_SQ     = 11'b00000000100,
        S_SQRTI  = 11'b00000001000,
        S_SQRT   = 11'b00000010000,
        S_CORDI  = 11'b00000100000,
        S_CORD   = 11'b00001000000,
        S_FA     = 11'b00010000000,
        S_FB     = 11'b00100000000,
        S_FC     = 11'b01000000000,
        S_OUT    = 11'b10000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] axis_reg, axis_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        ctrl.cmd   = CMD_NONE;
        ctrl.axis  = axis_reg;
        out_load   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_go)
                begin
                    ctrl.cmd   = CMD_LOAD;
                    axis_next  = 2'd0;
                    state_next = S_FILT;
                end
            end
            S_FILT:
            begin
                ctrl.cmd = CMD_FILT;
                if (axis_reg == 2'd2)
                begin
                    axis_next  = 2'd0;
                    state_next = S_SQ;
                end
                else
                    axis_next = axis_reg + 2'd1;
            end
            S_SQ:
            begin
                ctrl.cmd   = CMD_SQ;
                state_next = S_SQRTI;
            end
            S_SQRTI:
            begin
                ctrl.cmd   = CMD_SQRT_I;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                ctrl.cmd = CMD_SQRT;
                if (stat.sqrt_done)
                    state_next = S_CORDI;
            end
            S_CORDI:
            begin
                ctrl.cmd   = CMD_CORD_I;
                state_next = S_CORD;
            end
            S_CORD:
            begin
                ctrl.cmd = CMD_CORD;
                if (stat.cord_done)
                    state_next = S_FA;
            end
            S_FA:
            begin
                ctrl.cmd   = CMD_FUSE_A;
                state_next = S_FB;
            end
            S_FB:
            begin
                ctrl.cmd   = CMD_FUSE_B;
                state_next = S_FC;
            end
            S_FC:
            begin
                ctrl.cmd = CMD_FUSE_C;
                if (axis_reg == 2'd1)
                    state_next = S_OUT;
                else
                begin
                    axis_next  = 2'd1;
                    state_next = S_SQ;
                end
            end
            S_OUT:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    ctrl.cmd   = CMD_OUT;
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule
`default_nettype wire

// ===== rtl/core/imu_tcf_dp.sv =====
// Datapath for the IMU tilt filter: filter state, square root, CORDIC and
// fusion arithmetic. Depends on imu_tcf_pkg.
`default_nettype none
module imu_tcf_dp
    import imu_tcf_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ctrl_t              ctrl,
    input  wire logic        [15:0] alpha,
    input  wire logic signed [15:0] accel_x,
    input  wire logic signed [15:0] accel_y,
    input  wire logic signed [15:0] accel_z,
    input  wire logic signed [15:0] gyro_x,
    input  wire logic signed [15:0] gyro_y,
    input  wire logic signed [15:0] gyro_z,
    output stat_t                   stat,
    output logic signed [21:0]      pitch_out,
    output logic signed [21:0]      roll_out
);

    logic signed [31:0] af_reg [3];
    logic signed [31:0] gf_reg [3];
    logic signed [15:0] gp_reg [3];
    logic signed [31:0] est_reg [2];
    logic signed [15:0] ain_reg [3];
    logic signed [15:0] gin_reg [3];

    logic [62:0]        sqn_reg;
    logic [62:0]        sqr_reg;
    logic [62:0]        sqb_reg;
    logic [SqrtCntW-1:0] sqc_reg;
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [31:0] cz_reg;
    logic [StepW-1:0]   ci_reg;
    logic signed [31:0] gy_reg;
    logic signed [63:0] t_reg;
    logic signed [63:0] pa_reg, pb_reg;

    logic [1:0] ax;
    assign ax = ctrl.axis;

    // filter update for one axis
    logic signed [17:0] oma;
    logic signed [47:0] af_sum;
    logic signed [47:0] af_rnd;
    logic signed [31:0] af_new;
    logic signed [33:0] gt;
    logic signed [52:0] gprod;
    logic signed [36:0] g_rnd;
    logic signed [31:0] gf_new;

    always_comb
    begin
        oma    = $signed({1'b0, OneQ16}) - $signed({2'b0, alpha});
        af_sum = 48'(oma * $signed({ain_reg[ax], 15'd0}))
               + 48'($signed({1'b0, alpha}) * af_reg[ax]) + 48'sd32768;
        af_rnd = af_sum >>> 16;
        if (af_rnd > 48'(AccLim))
            af_new = AccLim;
        else if (af_rnd < -48'(AccLim))
            af_new = -AccLim;
        else
            af_new = af_rnd[31:0];
        gt     = 34'(gf_reg[ax]) + 34'($signed({gin_reg[ax][15], gin_reg[ax]}
                 - {gp_reg[ax][15], gp_reg[ax]}) * 34'sd4096);
        gprod  = 53'(oma * gt) + 53'sd32768;
        g_rnd  = 37'(gprod >>> 16);
        if (g_rnd > 37'sd2147483647)
            gf_new = 32'sh7fffffff;
        else if (g_rnd < -37'sd2147483648)
            gf_new = 32'sh80000000;
        else
            gf_new = g_rnd[31:0];
    end

    // operands per angle: a over sqrt(b^2 + c^2)
    logic signed [31:0] va, vb, vc;
    assign va = ax[0] ? af_reg[1] : af_reg[0];
    assign vb = ax[0] ? af_reg[0] : af_reg[1];
    assign vc = af_reg[2];

    logic [62:0] sq_sum;
    assign sq_sum = 63'(vb * vb) + 63'(vc * vc);

    logic [62:0] sq_trial;
    assign sq_trial = sqr_reg + sqb_reg;

    logic signed [33:0] xs, ys;
    assign xs = cx_reg >>> ci_reg;
    assign ys = cy_reg >>> ci_reg;

    logic signed [31:0] acc_ang;
    assign acc_ang = (cz_reg + 32'sd8) >>> 4;

    logic signed [31:0] est_sel, gf_sel;
    assign est_sel = est_reg[ax[0]];
    assign gf_sel  = gf_reg[ax[0]];

    logic signed [63:0] f_sum;
    logic signed [47:0] f_rnd;
    logic signed [31:0] f_new;
    always_comb
    begin
        f_sum = pa_reg + pb_reg + 64'sd32768;
        f_rnd = 48'(f_sum >>> 16);
        if (f_rnd > 48'sd2147483647)
            f_new = 32'sh7fffffff;
        else if (f_rnd < -48'sd2147483648)
            f_new = 32'sh80000000;
        else
            f_new = f_rnd[31:0];
    end

    function automatic logic signed [21:0] out22(input logic signed [31:0] e);
        logic signed [28:0] r;
        r = 29'((33'(e) + 33'sd8) >>> 4);
        if (r > 29'sd2097151)
            return 22'sh1fffff;
        else if (r < -29'sd2097152)
            return 22'sh200000;
        return r[21:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                af_reg[k] <= '0;
                gf_reg[k] <= '0;
                gp_reg[k] <= '0;
            end
            est_reg[0] <= '0;
            est_reg[1] <= '0;
        end
        else
        begin
            case (ctrl.cmd)
                CMD_FILT:
                begin
                    af_reg[ax] <= af_new;
                    gf_reg[ax] <= gf_new;
                    gp_reg[ax] <= gin_reg[ax];
                end
                CMD_FUSE_C: est_reg[ax[0]] <= f_new;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.cmd)
            CMD_LOAD:
            begin
                ain_reg[0] <= accel_x;
                ain_reg[1] <= accel_y;
                ain_reg[2] <= accel_z;
                gin_reg[0] <= gyro_x;
                gin_reg[1] <= gyro_y;
                gin_reg[2] <= gyro_z;
            end
            CMD_SQ: sqn_reg <= sq_sum;
            CMD_SQRT_I:
            begin
                sqr_reg <= '0;
                sqb_reg <= 63'(1) << 62;
                sqc_reg <= '0;
            end
            CMD_SQRT:
            begin
                if (sqn_reg >= sq_trial)
                begin
                    sqn_reg <= sqn_reg - sq_trial;
                    sqr_reg <= (sqr_reg >> 1) + sqb_reg;
                end
                else
                    sqr_reg <= sqr_reg >> 1;
                sqb_reg <= sqb_reg >> 2;
                sqc_reg <= sqc_reg + SqrtCntW'(1);
            end
            CMD_CORD_I:
            begin
                cx_reg <= 34'($signed({1'b0, sqr_reg[31:0]}));
                cy_reg <= 34'(va);
                cz_reg <= '0;
                ci_reg <= '0;
            end
            CMD_CORD:
            begin
                if (!(cx_reg == 0 && cy_reg == 0))
                begin
                    if (!cy_reg[33])
                    begin
                        cx_reg <= cx_reg + ys;
                        cy_reg <= cy_reg - xs;
                        cz_reg <= cz_reg + atan_lut(5'(ci_reg));
                    end
                    else
                    begin
                        cx_reg <= cx_reg - ys;
                        cy_reg <= cy_reg + xs;
                        cz_reg <= cz_reg - atan_lut(5'(ci_reg));
                    end
                end
                ci_reg <= ci_reg + StepW'(1);
            end
            CMD_FUSE_A:
                gy_reg <= 32'((64'(gf_sel) * $signed({1'b0, GyroDt})
                          + 64'sd8388608) >>> 24);
            CMD_FUSE_B:
            begin
                pa_reg <= 64'($signed({1'b0, WEst}) * (34'(est_sel) + 34'(gy_reg)));
                pb_reg <= 64'($signed({1'b0, WAcc}) * acc_ang);
            end
            CMD_OUT:
            begin
                pitch_out <= out22(est_reg[0]);
                roll_out  <= out22(est_reg[1]);
            end
            default: ;
        endcase
    end

    assign stat.sqrt_done = (sqc_reg == SqrtCntW'(SqrtSteps));
    assign stat.cord_done = (ci_reg == StepW'(CordicSteps - 1));

endmodule
`default_nettype wire

// ===== rtl/core/imu_tilt_complementary_filter_unit.sv =====
// IMU tilt complementary filter, top level: the filter update for each of the
// three axes, then per angle (pitch, then roll) the square, 32-step square root,
// 16-step CORDIC, setup and the fuse steps A, B and C, then the output load.
// One item at a time; output stalls delay the load. Reset clears filter state and
// estimates, lp_alpha to 49874. Depends on imu_tcf_pkg, imu_tcf_ctrl, imu_tcf_dp.
`default_nettype none
module imu_tilt_complementary_filter_unit
    import imu_tcf_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [15:0] accel_x,
    input  wire logic signed [15:0] accel_y,
    input  wire logic signed [15:0] accel_z,
    input  wire logic signed [15:0] gyro_x,
    input  wire logic signed [15:0] gyro_y,
    input  wire logic signed [15:0] gyro_z,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [21:0]      pitch_angle,
    output logic signed [21:0]      roll_angle,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic        [15:0] cfg_data
);

    logic [15:0] alpha_reg;
    logic        ov_reg;
    ctrl_t       ctrl;
    stat_t       stat;
    logic        busy, out_load, in_go;

    assign in_stall  = busy;
    assign in_go     = in_valid && !busy;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= AlphaReset;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                alpha_reg <= cfg_data;
            if (out_load)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end

    assign out_valid = ov_reg;

    imu_tcf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_go    (in_go),
        .out_free (!ov_reg || !out_stall),
        .stat     (stat),
        .ctrl     (ctrl),
        .busy     (busy),
        .out_load (out_load)
    );

    imu_tcf_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .alpha     (alpha_reg),
        .accel_x   (accel_x),
        .accel_y   (accel_y),
        .accel_z   (accel_z),
        .gyro_x    (gyro_x),
        .gyro_y    (gyro_y),
        .gyro_z    (gyro_z),
        .stat      (stat),
        .pitch_out (pitch_angle),
        .roll_out  (roll_angle)
    );

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> in_stall) else $error("item accepted while busy");
    a_load_frees: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid) else $error("result lost");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> !busy) else $error("controller not idle after result");
`endif

endmodule
`default_nettype wire

// ===== dv/tb_imu_tilt_complementary_filter_unit.sv =====
// Testbench for the IMU tilt complementary filter unit: drives six-axis samples
// and lp_alpha writes, predicts pitch and roll in fixed point and compares.
// Depends on imu_tcf_pkg and imu_tilt_complementary_filter_unit.
`default_nettype none
module tb_imu_tilt_complementary_filter_unit;
    import imu_tcf_pkg::*;

    typedef struct packed {
        logic signed [15:0] ax, ay, az, gx, gy, gz;
    } sample_t;

    typedef struct packed {
        logic signed [21:0] pitch, roll;
    } tilt_t;

    localparam int AtanTab [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
        58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2,
        1, 0};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    sample_t in_item = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [21:0] pitch_angle, roll_angle;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [15:0] cfg_data = '0;

    sample_t sample_q[$];
    tilt_t tilt_q[$];
    int fail_cnt = 0;
    bit calm = 1'b0;

    // predictor state
    longint m_alpha;
    longint m_accf[3];
    longint m_gyf[3];
    longint m_gprev[3];
    longint m_pitch, m_roll;

    always #10 clk = ~clk;

    imu_tilt_complementary_filter_unit i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .accel_x(in_item.ax), .accel_y(in_item.ay), .accel_z(in_item.az),
        .gyro_x(in_item.gx), .gyro_y(in_item.gy), .gyro_z(in_item.gz),
        .out_valid(out_valid), .out_stall(out_stall),
        .pitch_angle(pitch_angle), .roll_angle(roll_angle),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    function automatic longint floor_shr(longint v, int s);
        if (v >= 0)
            return v >>> s;
        return -(((-v) - 1) >>> s) - 1;
    endfunction

    function automatic longint round_shr(longint v, int s);
        return floor_shr(v + (longint'(1) << (s - 1)), s);
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else
                r >>= 1;
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint tilt_angle(longint y, longint x);
        longint z;
        longint xs, ys;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        for (int i = 0; i < CordicSteps && i < 24; i++) begin
            xs = floor_shr(x, i);
            ys = floor_shr(y, i);
            if (y >= 0) begin
                x = x + ys; y = y - xs; z += AtanTab[i];
            end else begin
                x = x - ys; y = y + xs; z -= AtanTab[i];
            end
        end
        return round_shr(z, 4);
    endfunction

    function automatic longint accel_tilt(int a, int b, int c);
        longint unsigned sq;
        sq = longint'(m_accf[b] * m_accf[b]) + longint'(m_accf[c] * m_accf[c]);
        return tilt_angle(m_accf[a], int_sqrt(sq));
    endfunction

    function automatic longint blend(longint est, longint gf, longint acc);
        longint gterm, t;
        gterm = round_shr(gf * 167772, 24);
        t = longint'(65536 - 1966) * (est + gterm) + 1966 * acc;
        return clamp(round_shr(t, 16), -64'sd2147483648, 64'sd2147483647);
    endfunction

    function automatic logic signed [21:0] to_out(longint est);
        return 22'(clamp(round_shr(est, 4), -2097152, 2097151));
    endfunction

    function automatic tilt_t predict_tilt(sample_t s);
        longint raw[6];
        longint oma, t, accp, accr;
        tilt_t r;
        raw = '{s.ax, s.ay, s.az, s.gx, s.gy, s.gz};
        oma = 65536 - m_alpha;
        for (int i = 0; i < 3; i++)
            m_accf[i] = clamp(round_shr(oma * raw[i] * 32768 + m_alpha * m_accf[i], 16),
                -64'sd1073741824, 64'sd1073741824);
        for (int i = 0; i < 3; i++) begin
            t = m_gyf[i] + (raw[3 + i] - m_gprev[i]) * 4096;
            m_gyf[i] = clamp(round_shr(oma * t, 16), -64'sd2147483648, 64'sd2147483647);
            m_gprev[i] = raw[3 + i];
        end
        accp = accel_tilt(0, 1, 2);
        accr = accel_tilt(1, 0, 2);
        m_pitch = blend(m_pitch, m_gyf[0], accp);
        m_roll = blend(m_roll, m_gyf[1], accr);
        r.pitch = to_out(m_pitch);
        r.roll = to_out(m_roll);
        return r;
    endfunction

    function automatic logic signed [15:0] rand_axis();
        case ($urandom_range(0, 9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'(int'($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    // sender: feed queued samples, predict each accepted one
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                tilt_q.push_back(predict_tilt(in_item));
                void'(sample_q.pop_front());
            end
            if (!(in_valid && in_stall)) begin
                if ((in_valid && !in_stall ? sample_q.size() > 0 : sample_q.size() > 0)
                    && (calm || $urandom_range(0, 99) >= 34)) begin
                    in_valid <= 1'b1;
                    in_item <= sample_q[0];
                end else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stall, check each accepted result
    always @(posedge clk) begin
        tilt_t exp_t;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (tilt_q.size() == 0) begin
                    $error("unexpected result pitch %0d roll %0d", pitch_angle, roll_angle);
                    fail_cnt++;
                end else begin
                    exp_t = tilt_q.pop_front();
                    if (pitch_angle !== exp_t.pitch) begin
                        $error("pitch_angle expected %0d actual %0d", exp_t.pitch, pitch_angle);
                        fail_cnt++;
                    end
                    if (roll_angle !== exp_t.roll) begin
                        $error("roll_angle expected %0d actual %0d", exp_t.roll, roll_angle);
                        fail_cnt++;
                    end
                end
            end
            out_stall <= !calm && ($urandom_range(0, 99) < 34);
        end
    end

    task automatic wait_drained();
        while (sample_q.size() != 0 || in_valid || tilt_q.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_alpha(logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        m_alpha = val;
    endtask

    task automatic queue_random(int n, bit flat);
        sample_t s;
        repeat (n) begin
            s = {rand_axis(), rand_axis(), rand_axis(), rand_axis(), rand_axis(),
                rand_axis()};
            // mostly a steady pose with a little noise, so the filters settle
            if (flat && $urandom_range(0, 3) != 0) begin
                s.ax = 16'(int'($urandom_range(0, 4000)) - 2000);
                s.ay = 16'(int'($urandom_range(0, 4000)) - 2000);
                s.az = 16'(16384 + int'($urandom_range(0, 400)) - 200);
                s.gx = 16'(int'($urandom_range(0, 200)) - 100);
                s.gy = 16'(int'($urandom_range(0, 200)) - 100);
            end
            sample_q.push_back(s);
        end
    endtask

    initial begin
        logic [15:0] alphas[5];
        m_alpha = 49874;
        for (int i = 0; i < 3; i++) begin
            m_accf[i] = 0; m_gyf[i] = 0; m_gprev[i] = 0;
        end
        m_pitch = 0;
        m_roll = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero vector, extremes, sign combinations
        sample_q.push_back('0);
        sample_q.push_back('0);
        sample_q.push_back({16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
        sample_q.push_back({16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
        sample_q.push_back({16'sh7fff, 16'sh0, 16'sh0, 16'sh8000, 16'sh7fff, 16'sh0});
        sample_q.push_back({16'sh0, 16'sh8000, 16'sh0, 16'sh7fff, 16'sh8000, 16'sh1});
        sample_q.push_back({16'sh0, 16'sh0, 16'sh4000, 16'sh0, 16'sh0, 16'shffff});
        sample_q.push_back({16'sh8000, 16'sh7fff, 16'sh8000, 16'sh1234, 16'shedcb, 16'sh5555});
        wait_drained();
        write_alpha(16'd0);
        sample_q.push_back('0);
        sample_q.push_back({16'sh7fff, 16'sh8000, 16'sh0, 16'sh7fff, 16'sh8000, 16'shaaaa});
        sample_q.push_back({16'sh0, 16'sh0, 16'sh0, 16'sh8000, 16'sh7fff, 16'sh0});
        sample_q.push_back('0);
        wait_drained();
        write_alpha(16'hffff);
        queue_random(6, 1'b0);
        wait_drained();

        alphas = '{16'd49874, 16'd0, 16'hffff, 16'd32768, 16'd60000};
        for (int p = 0; p < 7; p++) begin
            write_alpha(p < 5 ? alphas[p] : 16'($urandom));
            calm = (p == 3);
            queue_random(245, 1'b1);
            wait_drained();
        end
        calm = 1'b0;

        if (fail_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #(20 * 2000000);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
`default_nettype wire
